// ===== sv/wsmc_pkg.sv =====
// Shared types and constants for the wafer slot map classifier.
`timescale 1ns / 1ps

package wsmc_pkg;

  // Configuration port geometry and register field widths.
  localparam int unsigned CfgW    = 23;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FirstW  = 23;
  localparam int unsigned PitchW  = 16;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned StateW  = 3;
  // T +/- Mt needs one sign bit and one carry bit above the 16-bit fields.
  localparam int unsigned ThickW  = 18;
  // Window offsets relative to a slot base, including the minus-pitch set.
  localparam int unsigned OffW    = 19;

  localparam int unsigned MaxSlots   = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [FirstW-1:0] FirstReset   = 23'd2000;
  localparam logic [PitchW-1:0] PitchReset   = 16'd1000;
  localparam logic [PitchW-1:0] ThickReset   = 16'd100;
  localparam logic [PitchW-1:0] TMarginReset = 16'd10;
  localparam logic [PitchW-1:0] PMarginReset = 16'd10;
  localparam logic [SlotW-1:0]  CountReset   = 6'd25;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFirst   = 3'd0,
    CfgPitch   = 3'd1,
    CfgThick   = 3'd2,
    CfgTMargin = 3'd3,
    CfgPMargin = 3'd4,
    CfgCount   = 3'd5
  } cfg_idx_e;

  typedef enum logic [StateW-1:0] {
    SlotEmpty  = 3'd0,
    SlotSingle = 3'd1,
    SlotDouble = 3'd2,
    SlotCross  = 3'd3,
    SlotThin   = 3'd4
  } slot_state_e;

  // Offsets added to a slot base to form the four window thresholds.
  typedef struct packed {
    logic signed [OffW-1:0] hh;  // T + Mt
    logic signed [OffW-1:0] hl;  // T - Mt
    logic signed [OffW-1:0] lh;  // + Mp
    logic signed [OffW-1:0] ll;  // - Mp
  } win_off_t;

  // Registered configuration, with the derived sums already formed.
  typedef struct packed {
    logic [FirstW-1:0]        first;
    logic [PitchW-1:0]        pitch;
    logic [SlotW-1:0]         count;
    logic signed [ThickW-1:0] tpm;
    logic signed [ThickW-1:0] tmm;
    win_off_t                 cur;
    win_off_t                 nxt;
  } cfg_t;

endpackage

// ===== sv/wsmc_if.sv =====
// Valid/ready channel interfaces for edge pairs and slot results.
`timescale 1ns / 1ps

interface wsmc_pair_if #(
  parameter int unsigned POSITION_WIDTH = 24
) ();
  logic                             valid;
  logic                             ready;
  logic signed [POSITION_WIDTH-1:0] upper_edge;
  logic signed [POSITION_WIDTH-1:0] lower_edge;
  logic                             last_pair;

  modport source (output valid, output upper_edge, output lower_edge, output last_pair,
                  input ready);
  modport sink (input valid, input upper_edge, input lower_edge, input last_pair,
                output ready);
endinterface

interface wsmc_slot_if ();
  import wsmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [SlotW-1:0]  slot_number;
  slot_state_e       slot_state;
  logic              map_done;

  modport source (output valid, output slot_number, output slot_state, output map_done,
                  input ready);
  modport sink (input valid, input slot_number, input slot_state, input map_done,
                output ready);
endinterface

// ===== sv/wsmc_queue.sv =====
// Small register FIFO that decouples the pair front end from the slot sequencer.
`timescale 1ns / 1ps

module wsmc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             valid_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/wsmc_front.sv =====
// Front end: takes edge pairs, forms the thickness class and pushes them into the queue.
`timescale 1ns / 1ps

module wsmc_front #(
  parameter int unsigned POSITION_WIDTH = 24,
  localparam int unsigned EntryW = 2 * POSITION_WIDTH + 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  wsmc_pair_if.sink           pair_i,
  input  wsmc_pkg::cfg_t      cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic [EntryW-1:0]   q_data_o
);
  import wsmc_pkg::*;

  localparam int unsigned DiffW = POSITION_WIDTH + 1;
  localparam int unsigned CmpW  = POSITION_WIDTH + 2;

  logic                             s1_valid_q;
  logic signed [POSITION_WIDTH-1:0] s1_up_q;
  logic signed [POSITION_WIDTH-1:0] s1_lo_q;
  logic                             s1_last_q;
  logic signed [DiffW-1:0]          s1_diff_q;

  logic                             accept;
  logic signed [CmpW-1:0]           diff_x, tpm_x, tmm_x;
  slot_state_e                      thick;

  assign pair_i.ready = !s1_valid_q || !q_full_i;
  assign accept       = pair_i.valid && pair_i.ready;
  assign q_push_o     = s1_valid_q && !q_full_i;

  // Thickness is independent of the slot, so it is settled here once per pair.
  always_comb begin
    diff_x = CmpW'(s1_diff_q);
    tpm_x  = CmpW'(cfg_i.tpm);
    tmm_x  = CmpW'(cfg_i.tmm);
    if (diff_x > tpm_x) begin
      thick = SlotDouble;
    end else if (diff_x < tmm_x) begin
      thick = SlotThin;
    end else begin
      thick = SlotSingle;
    end
  end

  assign q_data_o = {s1_up_q, s1_lo_q, s1_last_q, thick};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (q_push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_up_q   <= pair_i.upper_edge;
      s1_lo_q   <= pair_i.lower_edge;
      s1_last_q <= pair_i.last_pair;
      s1_diff_q <= $signed({pair_i.upper_edge[POSITION_WIDTH-1], pair_i.upper_edge})
                 - $signed({pair_i.lower_edge[POSITION_WIDTH-1], pair_i.lower_edge});
    end
  end

endmodule

// ===== sv/wsmc_back.sv =====
// Back end: walks the slots for each queued pair and issues slot results.
`timescale 1ns / 1ps

module wsmc_back #(
  parameter int unsigned POSITION_WIDTH = 24,
  localparam int unsigned EntryW = 2 * POSITION_WIDTH + 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wsmc_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  logic [EntryW-1:0] q_data_i,
  output logic              q_pop_o,
  wsmc_slot_if.source       slot_o
);
  import wsmc_pkg::*;

  // Wide enough for any slot base plus offsets and any sign-extended edge.
  localparam int unsigned CW    = ((POSITION_WIDTH > 25) ? POSITION_WIDTH : 25) + 1;
  localparam int unsigned ProdW = PitchW + SlotW;

  typedef enum logic [2:0] {
    SIdle, SMul, SBase, SThr, SCls, SCross, SLast
  } state_e;

  typedef enum logic [2:0] {
    WinLl, WinLi, WinHi, WinHh, WinGap
  } win_e;

  typedef struct packed {
    logic signed [CW-1:0] hh;
    logic signed [CW-1:0] hl;
    logic signed [CW-1:0] lh;
    logic signed [CW-1:0] ll;
  } thr_t;

  function automatic thr_t thresholds(input logic signed [CW-1:0] b, input win_off_t o);
    thr_t r;
    r.hh = b + CW'($signed(o.hh));
    r.hl = b + CW'($signed(o.hl));
    r.lh = b + CW'($signed(o.lh));
    r.ll = b + CW'($signed(o.ll));
    return r;
  endfunction

  // Windows are tried high-high, high-in, low-in, low-low; the rest is a gap.
  function automatic win_e window(input logic signed [CW-1:0] p, input thr_t t);
    logic signed [CW-1:0] hh, hl, lh, ll;
    win_e                 w;
    hh = $signed(t.hh);
    hl = $signed(t.hl);
    lh = $signed(t.lh);
    ll = $signed(t.ll);
    if (p > hh) begin
      w = WinHh;
    end else if (p > hl && p < hh) begin
      w = WinHi;
    end else if (p > ll && p < lh) begin
      w = WinLi;
    end else if (p < ll) begin
      w = WinLl;
    end else begin
      w = WinGap;
    end
    return w;
  endfunction

  state_e                           state_q, state_d;
  logic signed [POSITION_WIDTH-1:0] up_q, up_d;
  logic signed [POSITION_WIDTH-1:0] lo_q, lo_d;
  logic                             last_q, last_d;
  slot_state_e                      thick_q, thick_d;
  logic [SlotW-1:0]                 done_q, done_d;
  logic [ProdW-1:0]                 prod_q, prod_d;
  logic signed [CW-1:0]             base_q, base_d;
  thr_t                             cur_q, cur_d;
  thr_t                             nxt_q, nxt_d;
  logic                             out_valid_q, out_valid_d;
  logic [SlotW-1:0]                 out_num_q, out_num_d;
  slot_state_e                      out_state_q, out_state_d;
  logic                             out_done_q, out_done_d;

  logic [SlotW-1:0]     slot, slot_m1;
  logic                 more, out_free, emit;
  slot_state_e          code;
  logic signed [CW-1:0] up_x, lo_x;
  win_e                 wu, wl, wn;
  logic                 upper_ok, both_low, pass_next;
  state_e               finish_state;

  assign slot     = cfg_i.count - done_q;
  assign slot_m1  = slot - SlotW'(1);
  assign more     = (done_q < cfg_i.count);
  assign out_free = !out_valid_q || slot_o.ready;

  assign up_x = CW'(up_q);
  assign lo_x = CW'(lo_q);
  assign wu   = window(up_x, cur_q);
  assign wl   = window(lo_x, cur_q);
  assign wn   = window(lo_x, nxt_q);

  assign upper_ok     = (wu != WinLl) && (wu != WinLi);
  assign both_low     = (wu == WinLl) && (wl == WinLl);
  assign pass_next    = (wn != WinLl) && (wn != WinLi);
  assign finish_state = last_q ? SLast : SIdle;

  always_comb begin
    state_d     = state_q;
    up_d        = up_q;
    lo_d        = lo_q;
    last_d      = last_q;
    thick_d     = thick_q;
    done_d      = done_q;
    prod_d      = prod_q;
    base_d      = base_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    out_valid_d = out_valid_q && !slot_o.ready;
    out_num_d   = out_num_q;
    out_state_d = out_state_q;
    out_done_d  = out_done_q;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    code        = SlotEmpty;

    unique case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          up_d    = q_data_i[EntryW-1 -: POSITION_WIDTH];
          lo_d    = q_data_i[StateW+POSITION_WIDTH:StateW+1];
          last_d  = q_data_i[StateW];
          thick_d = slot_state_e'(q_data_i[StateW-1:0]);
          state_d = SMul;
        end
      end
      SMul: begin
        if (more) begin
          prod_d  = ProdW'(cfg_i.pitch) * ProdW'(slot_m1);
          state_d = SBase;
        end else begin
          state_d = finish_state;
        end
      end
      SBase: begin
        base_d  = $signed(CW'(cfg_i.first)) + $signed(CW'(prod_q));
        state_d = SThr;
      end
      SThr: begin
        cur_d   = thresholds(base_q, cfg_i.cur);
        nxt_d   = thresholds(base_q, cfg_i.nxt);
        state_d = SCls;
      end
      SCls: begin
        if (upper_ok && wl == WinLi) begin
          if (out_free) begin
            emit    = 1'b1;
            code    = thick_q;
            state_d = finish_state;
          end
        end else if (both_low) begin
          if (slot > SlotW'(1)) begin
            if (pass_next) begin
              if (out_free) begin
                emit    = 1'b1;
                code    = SlotCross;
                state_d = SCross;
              end
            end else if (out_free) begin
              // Slot is empty; try the same pair one slot lower.
              emit    = 1'b1;
              code    = SlotEmpty;
              base_d  = base_q - $signed(CW'(cfg_i.pitch));
              state_d = SThr;
            end
          end else if (out_free) begin
            emit    = 1'b1;
            code    = SlotCross;
            state_d = finish_state;
          end
        end else begin
          state_d = finish_state;
        end
      end
      SCross: begin
        if (out_free) begin
          emit    = 1'b1;
          code    = SlotCross;
          state_d = finish_state;
        end
      end
      SLast: begin
        if (more) begin
          if (out_free) begin
            emit = 1'b1;
            code = SlotEmpty;
          end
        end else begin
          done_d  = '0;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      out_num_d   = slot;
      out_state_d = code;
      out_done_d  = (({1'b0, done_q} + (SlotW + 1)'(1)) >= {1'b0, cfg_i.count});
      done_d      = done_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      up_q        <= '0;
      lo_q        <= '0;
      last_q      <= 1'b0;
      thick_q     <= SlotEmpty;
      done_q      <= '0;
      prod_q      <= '0;
      base_q      <= '0;
      cur_q       <= '0;
      nxt_q       <= '0;
      out_valid_q <= 1'b0;
      out_num_q   <= '0;
      out_state_q <= SlotEmpty;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      up_q        <= up_d;
      lo_q        <= lo_d;
      last_q      <= last_d;
      thick_q     <= thick_d;
      done_q      <= done_d;
      prod_q      <= prod_d;
      base_q      <= base_d;
      cur_q       <= cur_d;
      nxt_q       <= nxt_d;
      out_valid_q <= out_valid_d;
      out_num_q   <= out_num_d;
      out_state_q <= out_state_d;
      out_done_q  <= out_done_d;
    end
  end

  assign slot_o.valid       = out_valid_q;
  assign slot_o.slot_number = out_num_q;
  assign slot_o.slot_state  = out_state_q;
  assign slot_o.map_done    = out_done_q;

endmodule

// ===== sv/wafer_slot_map_classifier_unit.sv =====
// Top level of the wafer slot map classifier: configuration registers, front end, queue, back end.
`timescale 1ns / 1ps

// The unit maps a wafer carrier from mapping-sensor edge pairs. Each transfer on pair_i
// carries the upper and lower edge of one detected object; the unit walks the slots from
// the top slot down and reports each slot on slot_o as empty, single, double, cross or
// thin, counted from one at the bottom, with map_done set on the result for slot one.
// The pair that carries last_pair reports every remaining slot as empty and restarts the
// walk for the next scan; pairs arriving after the map is complete give no result. A
// front stage takes a pair and forms its thickness class, and a two-entry queue hands it
// to a slot sequencer, so the sensor side keeps transferring while results wait on
// slot_o. The sequencer takes a pair that lands on its slot through pop, slot offset
// multiply, base add, window thresholds and classification; each empty slot passed over
// repeats thresholds and classification, a second cross result has its own state, and
// the last pair reports each remaining slot, then restarts. Results leave one per cycle
// while slot_o is ready and a result is due. The user must write configuration through
// cfg_we_i, cfg_idx_i and cfg_data_i only while the unit is idle; the unit does not check.
module wafer_slot_map_classifier_unit #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wsmc_pkg::CfgW-1:0]     cfg_data_i,
  wsmc_pair_if.sink                     pair_i,
  wsmc_slot_if.source                   slot_o
);
  import wsmc_pkg::*;

  // One queue entry holds both edges, the last-pair flag and the thickness class.
  localparam int unsigned EntryW = 2 * POSITION_WIDTH + 4;

  // Configuration registers as written.
  logic [FirstW-1:0] first_q;
  logic [PitchW-1:0] pitch_q;
  logic [PitchW-1:0] thick_q;
  logic [PitchW-1:0] tmargin_q;
  logic [PitchW-1:0] pmargin_q;
  logic [SlotW-1:0]  count_q;

  // Derived configuration, refreshed every cycle so that no sum is formed on the fly.
  cfg_t cfg_d, cfg_q;

  logic                   q_push, q_full, q_pop, q_valid;
  logic [EntryW-1:0]      q_wdata, q_rdata;
  logic signed [ThickW-1:0] tpm, tmm;
  logic signed [OffW-1:0]   pitch_x, mp_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= FirstReset;
      pitch_q   <= PitchReset;
      thick_q   <= ThickReset;
      tmargin_q <= TMarginReset;
      pmargin_q <= PMarginReset;
      count_q   <= CountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFirst:   first_q   <= cfg_data_i[FirstW-1:0];
        CfgPitch:   pitch_q   <= cfg_data_i[PitchW-1:0];
        CfgThick:   thick_q   <= cfg_data_i[PitchW-1:0];
        CfgTMargin: tmargin_q <= cfg_data_i[PitchW-1:0];
        CfgPMargin: pmargin_q <= cfg_data_i[PitchW-1:0];
        CfgCount:   count_q   <= cfg_data_i[SlotW-1:0];
        default: ;
      endcase
    end
  end

  // The window offsets for the slot below subtract the pitch, so the sequencer can test
  // a lower edge against the next slot with the same base register.
  always_comb begin
    tpm     = $signed({2'b00, thick_q}) + $signed({2'b00, tmargin_q});
    tmm     = $signed({2'b00, thick_q}) - $signed({2'b00, tmargin_q});
    pitch_x = $signed({3'b000, pitch_q});
    mp_x    = $signed({3'b000, pmargin_q});

    cfg_d.first = first_q;
    cfg_d.pitch = pitch_q;
    cfg_d.tpm   = tpm;
    cfg_d.tmm   = tmm;

    // A slot count of zero acts as one, and one above the maximum is clamped.
    if (count_q == '0) begin
      cfg_d.count = SlotW'(1);
    end else if (count_q > SlotW'(MaxSlots)) begin
      cfg_d.count = SlotW'(MaxSlots);
    end else begin
      cfg_d.count = count_q;
    end

    cfg_d.cur.hh = OffW'(tpm);
    cfg_d.cur.hl = OffW'(tmm);
    cfg_d.cur.lh = mp_x;
    cfg_d.cur.ll = -mp_x;
    cfg_d.nxt.hh = OffW'(tpm) - pitch_x;
    cfg_d.nxt.hl = OffW'(tmm) - pitch_x;
    cfg_d.nxt.lh = mp_x - pitch_x;
    cfg_d.nxt.ll = -mp_x - pitch_x;
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  wsmc_front #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pair_i   (pair_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  wsmc_queue #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .valid_o (q_valid)
  );

  wsmc_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .slot_o    (slot_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the wafer slot map classifier unit.
`timescale 1ns / 1ps

module testbench;
  import wsmc_pkg::*;

  // The sender's idle bursts, the receiver's stall bursts and the long receiver hold-off
  // are all counted in clock cycles.
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned PhaseItems    = 16;
  localparam int unsigned HoldCycles    = 400;
  // A pair that gives no result can still be in flight after the last result, so every
  // drain waits this long before the configuration is touched again.
  localparam int unsigned SettleCycles  = 100;
  // Quiet cycles (no transfer on either channel) before the run is declared hung.
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ReportLimit   = 10;

  // Where a position falls relative to a slot base.
  typedef enum int {
    WinLowLow,
    WinLowIn,
    WinHighIn,
    WinHighHigh,
    WinGap
  } win_e;

  typedef struct {
    logic [SlotW-1:0] num;
    slot_state_e      st;
    logic             done;
  } slot_res_t;

  typedef struct {
    longint up;
    longint lo;
  } edge_pair_t;

  // The scoreboard keeps its own copy of the registers and of the walk state. Each
  // accepted pair is mapped into the slot results that it causes, and every result that
  // leaves the unit is checked against the oldest one still waiting.
  class slot_map_sb;
    longint           first_pos;
    longint           pitch;
    longint           thick;
    longint           t_margin;
    longint           p_margin;
    longint           count_reg;
    int unsigned      slots_done;
    slot_res_t        exp_slots[$];
    int unsigned      errors;

    function new();
      first_pos  = 2000;
      pitch      = 1000;
      thick      = 100;
      t_margin   = 10;
      p_margin   = 10;
      count_reg  = 25;
      slots_done = 0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        CfgFirst:   first_pos = longint'(data[FirstW-1:0]);
        CfgPitch:   pitch     = longint'(data[PitchW-1:0]);
        CfgThick:   thick     = longint'(data[PitchW-1:0]);
        CfgTMargin: t_margin  = longint'(data[PitchW-1:0]);
        CfgPMargin: p_margin  = longint'(data[PitchW-1:0]);
        CfgCount:   count_reg = longint'(data[SlotW-1:0]);
        default: ;
      endcase
    endfunction

    // Slot count clamped to the range that the unit supports.
    function int unsigned eff_count();
      if (count_reg < 1) return 1;
      if (count_reg > MaxSlots) return MaxSlots;
      return int'(count_reg);
    endfunction

    function longint base_of(int unsigned slot);
      return first_pos + pitch * longint'(slot - 1);
    endfunction

    function win_e window(longint p, longint b);
      if (p > b + thick + t_margin) return WinHighHigh;
      if (p > b + thick - t_margin && p < b + thick + t_margin) return WinHighIn;
      if (p > b - p_margin && p < b + p_margin) return WinLowIn;
      if (p < b - p_margin) return WinLowLow;
      return WinGap;
    endfunction

    function slot_state_e thick_class(longint h);
      if (h > thick + t_margin) return SlotDouble;
      if (h < thick - t_margin) return SlotThin;
      return SlotSingle;
    endfunction

    function void push_slot(int unsigned n, slot_state_e st);
      slot_res_t r;
      r.num = SlotW'(n - slots_done);
      r.st  = st;
      slots_done++;
      r.done = (slots_done >= n);
      exp_slots.push_back(r);
    endfunction

    function void note_pair(logic signed [23:0] up_e, logic signed [23:0] lo_e,
                            logic is_last);
      longint      up;
      longint      lo;
      longint      b;
      int unsigned n;
      int unsigned s;
      win_e        wu;
      win_e        wl;
      win_e        wn;
      up = up_e;
      lo = lo_e;
      n  = eff_count();
      while (slots_done < n) begin
        s  = n - slots_done;
        b  = base_of(s);
        wu = window(up, b);
        wl = window(lo, b);
        if (wu != WinLowLow && wu != WinLowIn && wl == WinLowIn) begin
          push_slot(n, thick_class(up - lo));
          break;
        end
        if (wu == WinLowLow && wl == WinLowLow) begin
          if (s > 1) begin
            // A low lower edge that is still above the next slot down spans two slots.
            wn = window(lo, b - pitch);
            if (wn != WinLowLow && wn != WinLowIn) begin
              push_slot(n, SlotCross);
              push_slot(n, SlotCross);
              break;
            end
            push_slot(n, SlotEmpty);
            continue;
          end
          push_slot(n, SlotCross);
          break;
        end
        break;
      end
      if (is_last) begin
        while (slots_done < n) push_slot(n, SlotEmpty);
        slots_done = 0;
      end
    endfunction

    function void check_slot(logic [SlotW-1:0] num, slot_state_e st, logic done);
      slot_res_t e;
      if (exp_slots.size() == 0) begin
        if (errors < ReportLimit)
          $display("unexpected slot result: slot %0d state %0d done %0d", num, st, done);
        errors++;
        return;
      end
      e = exp_slots.pop_front();
      if (num !== e.num || st !== e.st || done !== e.done) begin
        if (errors < ReportLimit)
          $display("slot result mismatch: expected slot %0d state %0d done %0d, got %0d %0d %0d",
                   e.num, e.st, e.done, num, st, done);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return exp_slots.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;

  wsmc_pair_if #(.POSITION_WIDTH(24)) pair_if ();
  wsmc_slot_if                        slot_if ();

  slot_map_sb  sb = new();
  bit          send_idle;
  bit          recv_stall;
  bit          hold_req;
  int unsigned phase_cnt;
  int unsigned quiet_cycles;

  wafer_slot_map_classifier_unit #(
    .POSITION_WIDTH(24)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pair_i    (pair_if),
    .slot_o    (slot_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Everything that crosses the block boundary is observed at the clock edge, before the
  // nonblocking updates of that edge land, so register writes, pair transfers and result
  // transfers are all seen with the values that the unit itself samples.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (pair_if.valid && pair_if.ready)
        sb.note_pair(pair_if.upper_edge, pair_if.lower_edge, pair_if.last_pair);
      if (slot_if.valid && slot_if.ready)
        sb.check_slot(slot_if.slot_number, slot_if.slot_state, slot_if.map_done);
    end
  end

  // Watchdog: only cycles without any transfer count toward the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (pair_if.valid && pair_if.ready) || (slot_if.valid && slot_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result receiver. It is ready by default, stalls in random bursts when enabled, and
  // once per run holds off for a long stretch so that the pair side backs up.
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        slot_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (recv_stall && $urandom_range(0, 5) == 0) begin
        slot_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        slot_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic longint rand_span(longint lo_v, longint hi_v);
    if (hi_v <= lo_v) return lo_v;
    return lo_v + longint'($urandom_range(32'(hi_v - lo_v), 0));
  endfunction

  // Offers one pair and returns at the edge that transfers it. Valid is left high so that
  // back-to-back pairs keep the channel busy; it only drops for an idle burst or a drain.
  task automatic send_pair(input longint up, input longint lo, input bit is_last);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      pair_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    pair_if.valid      <= 1'b1;
    pair_if.upper_edge <= up[23:0];
    pair_if.lower_edge <= lo[23:0];
    pair_if.last_pair  <= is_last;
    do @(posedge clk_i); while (!pair_if.ready);
    phase_cnt++;
  endtask

  // Stops offering pairs and waits until every predicted result has been transferred,
  // then gives pairs that cause no result time to leave the pipeline.
  task automatic drain();
    pair_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input longint val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgW-1:0];
    @(posedge clk_i);
  endtask

  // Hand-picked pairs under the reset configuration: every slot class, pairs that pass
  // over empty slots, discarded pairs at the edge extremes, a map finished before its
  // last pair with surplus pairs after it, and edges sitting exactly on window borders.
  task automatic directed_part();
    send_pair(sb.base_of(25) + 100, sb.base_of(25), 1'b0);
    send_pair(sb.base_of(24) + 200, sb.base_of(24), 1'b0);
    send_pair(sb.base_of(23) + 50, sb.base_of(23), 1'b0);
    // Slots 22 and 21 are passed over as empty before this wafer lands in slot 20.
    send_pair(sb.base_of(20) + 100, sb.base_of(20) + 5, 1'b0);
    // Both edges below slot 19 but above slot 18: a wafer lying across two slots.
    send_pair(sb.base_of(19) - 400, sb.base_of(19) - 500, 1'b0);
    send_pair(-64'sd8388608, 64'sd8388607, 1'b0);
    // The last pair is discarded itself and fills the rest of the map as empty.
    send_pair(64'sd8388607, -64'sd8388608, 1'b1);
    // Upper edge exactly at base plus thickness plus margin falls in no window but is not low.
    send_pair(sb.base_of(25) + 110, sb.base_of(25), 1'b1);
    // An object below slot one: every slot above is empty and slot one is cross, which
    // completes the map before the last pair arrives.
    send_pair(1100, 1000, 1'b0);
    send_pair(sb.base_of(25) + 100, sb.base_of(25), 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(-1, -1, 1'b1);
    // Lower edge exactly at base plus position margin lands in the gap: discarded.
    send_pair(sb.base_of(25) + 100, sb.base_of(25) + 10, 1'b0);
    send_pair(sb.base_of(25) + 100, sb.base_of(25) - 9, 1'b1);
  endtask

  // Writes all six registers. Most phases get a plausible carrier geometry; some push
  // single registers to their extremes, including slot counts outside the legal range.
  task automatic setup_phase(input int unsigned p);
    longint f;
    longint pt;
    longint t;
    longint mt;
    longint mp;
    longint c;
    pt = rand_span(300, 3000);
    t  = rand_span(pt / 20 + 1, pt / 5);
    mt = rand_span(0, t / 4);
    mp = rand_span(1, pt / 10);
    f  = rand_span(0, 200000);
    c  = rand_span(1, 32);
    case (p)
      2: begin
        f = 0;
        c = 32;
      end
      3: c = 0;
      4: c = 63;
      5: begin
        f  = 8388607;
        pt = 65535;
        t  = 65535;
        mt = 65535;
        mp = 65535;
      end
      6: begin
        pt = 1;
        t  = 1;
        mt = 0;
        mp = 0;
        c  = 2;
      end
      7: c = 25;
      8: c = 1;
      9: begin
        mt = 0;
        mp = 1;
      end
      default: ;
    endcase
    write_cfg(CfgFirst, f);
    write_cfg(CfgPitch, pt);
    write_cfg(CfgThick, t);
    write_cfg(CfgTMargin, mt);
    write_cfg(CfgPMargin, mp);
    write_cfg(CfgCount, c);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One scan from the top slot down with random content: slots are left empty, filled
  // with single, double or thin wafers, crossed, or hit by noise pairs. An unfinished
  // scan stops halfway without a last pair so the next phase starts mid map.
  task automatic run_scan(input bit finish);
    edge_pair_t  scan_q[$];
    edge_pair_t  pr;
    int          s;
    int unsigned n;
    int unsigned act;
    longint      b;
    longint      h;
    n = sb.eff_count();
    s = n;
    while (s >= 1 && (finish || s > int'(n / 2))) begin
      act = $urandom_range(0, 99);
      b   = sb.base_of(s);
      if (act < 25) begin
        s--;
      end else if (act < 75) begin
        pr.lo = b + ((sb.p_margin > 0) ? rand_span(1 - sb.p_margin, sb.p_margin - 1) : 0);
        case ($urandom_range(0, 3))
          0: h = sb.thick;
          1: h = sb.thick + sb.t_margin + 1 + rand_span(0, 50);
          2: h = sb.thick - sb.t_margin - 1 - rand_span(0, 50);
          default: h = sb.thick + rand_span(-sb.t_margin, sb.t_margin);
        endcase
        pr.up = pr.lo + h;
        scan_q.push_back(pr);
        s--;
      end else if (act < 88) begin
        if (s > 1) begin
          pr.lo = b - sb.pitch + sb.p_margin + 1 + rand_span(0, sb.pitch / 2);
          s -= 2;
        end else begin
          pr.lo = b - sb.p_margin - 1 - rand_span(0, 100);
          s--;
        end
        pr.up = pr.lo + rand_span(0, sb.thick);
        scan_q.push_back(pr);
      end else begin
        pr.up = longint'($urandom);
        pr.lo = longint'($urandom);
        scan_q.push_back(pr);
        if ($urandom_range(0, 1) == 1) s--;
      end
    end
    // Sometimes the last pair is an extra noise pair, possibly after the map is complete.
    if (finish && (scan_q.size() == 0 || $urandom_range(0, 2) == 0)) begin
      pr.up = longint'($urandom);
      pr.lo = longint'($urandom);
      scan_q.push_back(pr);
    end
    foreach (scan_q[i])
      send_pair(scan_q[i].up, scan_q[i].lo, finish && (i == scan_q.size() - 1));
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgFirst;
    cfg_data_i         <= '0;
    pair_if.valid      <= 1'b0;
    pair_if.upper_edge <= '0;
    pair_if.lower_edge <= '0;
    pair_if.last_pair  <= 1'b0;
    slot_if.ready      <= 1'b0;
    send_idle  = 1'b1;
    recv_stall = 1'b1;
    hold_req   = 1'b0;
    phase_cnt  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_part();
    drain();

    for (int unsigned p = 1; p < NumPhases; p++) begin
      setup_phase(p);
      // The final phase runs at full rate on both sides.
      send_idle  = (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      recv_stall = (p != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      // With all 32 slots in play the long hold-off lets the pair side fill and stall.
      if (p == 2) hold_req = 1'b1;
      phase_cnt = 0;
      while (phase_cnt < PhaseItems) run_scan(1'b1);
      // Leave a map half done so that the next phase lowers the slot count mid scan.
      if (p == 7) run_scan(1'b0);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wsmc_pkg.sv
sv/wsmc_if.sv
sv/wsmc_queue.sv
sv/wsmc_front.sv
sv/wsmc_back.sv
sv/wafer_slot_map_classifier_unit.sv
verif/testbench.sv
